[sv/kmp_substring_search_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef KMP_SUBSTRING_SEARCH_CORE_MACROS_SVH
`define KMP_SUBSTRING_SEARCH_CORE_MACROS_SVH

// check while out of reset
`define KMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define KMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/kmp_pkg.sv]
package kmp_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int DATA_W          = 8;
  localparam int POS_W           = 32;
  localparam int STEP_W          = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SETUP  = 3'd1;
  localparam step_t STEP_READ   = 3'd2;
  localparam step_t STEP_CMP    = 3'd3;
  localparam step_t STEP_COMMIT = 3'd4;
  localparam step_t STEP_EMIT   = 3'd5;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_SETUP,
    DP_READ,
    DP_CMP,
    DP_COMMIT,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ACCEPT,
    CND_WALK,
    CND_TEXT,
    CND_FREE
  } cnd_sel_t;

  typedef struct packed {
    dp_op_t   op;
    cnd_sel_t cnd_a;
    step_t    tgt_a;
    cnd_sel_t cnd_b;
    step_t    tgt_b;
    step_t    tgt_else;
  } ucw_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic text;
    logic out_free;
  } cond_t;

  function automatic ucw_t ucw_rom(step_t s);
    ucw_t w;
    case (s)
      STEP_IDLE:   w = '{DP_ACCEPT, CND_ACCEPT, STEP_SETUP, CND_NEVER, STEP_IDLE, STEP_IDLE};
      STEP_SETUP:  w = '{DP_SETUP, CND_WALK, STEP_READ, CND_TEXT, STEP_EMIT, STEP_IDLE};
      STEP_READ:   w = '{DP_READ, CND_NEVER, STEP_CMP, CND_NEVER, STEP_CMP, STEP_CMP};
      STEP_CMP:    w = '{DP_CMP, CND_WALK, STEP_READ, CND_NEVER, STEP_COMMIT, STEP_COMMIT};
      STEP_COMMIT: w = '{DP_COMMIT, CND_TEXT, STEP_EMIT, CND_NEVER, STEP_IDLE, STEP_IDLE};
      STEP_EMIT:   w = '{DP_EMIT, CND_FREE, STEP_IDLE, CND_NEVER, STEP_EMIT, STEP_EMIT};
      default:     w = '{DP_NOP, CND_NEVER, STEP_IDLE, CND_NEVER, STEP_IDLE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[sv/kmp_seq.sv]
module kmp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  kmp_pkg::cond_t  cond,
  output kmp_pkg::ucw_t   ucw
);

  kmp_pkg::step_t step_r;
  kmp_pkg::step_t step_nxt;
  logic           hit_a;
  logic           hit_b;

  function automatic logic cond_hit(kmp_pkg::cnd_sel_t sel, kmp_pkg::cond_t c);
    logic h;
    case (sel)
      kmp_pkg::CND_ACCEPT: h = c.accept;
      kmp_pkg::CND_WALK:   h = c.walk;
      kmp_pkg::CND_TEXT:   h = c.text;
      kmp_pkg::CND_FREE:   h = c.out_free;
      default:             h = 1'b0;
    endcase
    return h;
  endfunction

  assign ucw   = kmp_pkg::ucw_rom(step_r);
  assign hit_a = cond_hit(ucw.cnd_a, cond);
  assign hit_b = cond_hit(ucw.cnd_b, cond);

  always_comb begin
    if (hit_a) begin
      step_nxt = ucw.tgt_a;
    end else if (hit_b) begin
      step_nxt = ucw.tgt_b;
    end else begin
      step_nxt = ucw.tgt_else;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= kmp_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[sv/kmp_substring_search_core.sv]
// KMP substring search core.
// Input channel (in_valid / in_stall): one beat per byte. in_operation = 0 appends
// in_data to the pattern and builds its prefix entry; in_operation = 1 runs in_data
// through the matcher. in_restart starts a new pattern or a new text; in_last is
// echoed with the text result.
// Result channel (out_valid / out_stall): one beat per text byte, none per pattern
// byte. out_found and out_match_index hold the first match of the current text.
// Steps: a microcoded sequencer does each comparison as a read and a compare step
// on the single read ports of the pattern store and prefix table. A pattern byte
// runs only setup when the store is empty or full, else setup, c read/compare pairs
// for c comparisons and commit. A text byte runs setup then emit when matched,
// overflowed or pattern empty, else adds c pairs and commit; c averages under two.
// The output register lets the next beat be accepted while a result waits; a text
// result that finds the register still stalled waits in the emit step.
// Reset clears lengths, flags, position and the output valid; the stores need no
// clearing since only written entries are read.
module kmp_substring_search_core #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [kmp_pkg::DATA_W-1:0] in_data,
  input  logic                       in_restart,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [kmp_pkg::POS_W-1:0]  out_match_index,
  output logic                       out_pattern_overflow,
  output logic                       out_end_of_text
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_W = kmp_pkg::POS_W;
  localparam int DATA_W = kmp_pkg::DATA_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  kmp_pkg::ucw_t  ucw;
  kmp_pkg::cond_t cond;

  logic [DATA_W-1:0] pat_mem [MAX_PATTERN];
  logic [IDX_W-1:0]  pre_mem [MAX_PATTERN];

  logic              pat_we;
  logic [IDX_W-1:0]  pat_wa;
  logic              pre_we;
  logic [IDX_W-1:0]  pre_wa;
  logic [IDX_W-1:0]  pre_wd;
  logic [IDX_W-1:0]  pat_ra;
  logic [IDX_W-1:0]  pre_ra;
  logic [LEN_W-1:0]  jm1;
  logic [DATA_W-1:0] pat_rd_r;
  logic [IDX_W-1:0]  pre_rd_r;

  logic              op_r, op_nxt;
  logic [DATA_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  logic [POS_W-1:0]  pos_at_r, pos_at_nxt;

  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [LEN_W-1:0]  bpl_r, bpl_nxt;
  logic [LEN_W-1:0]  mlen_r, mlen_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  mstart_r, mstart_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_index_r, out_index_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_eot_r, out_eot_nxt;

  logic              accept;
  logic              walk;
  logic              out_free;
  logic [POS_W-1:0]  pos_base;

  kmp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ucw   (ucw)
  );

  assign accept   = in_valid && (ucw.op == kmp_pkg::DP_ACCEPT);
  assign in_stall = (ucw.op != kmp_pkg::DP_ACCEPT);
  assign out_free = !out_valid_r || !out_stall;
  assign pos_base = in_restart ? '0 : pos_r;

  assign cond.accept   = accept;
  assign cond.walk     = walk;
  assign cond.text     = op_r;
  assign cond.out_free = out_free;

  assign jm1    = j_r - LEN_W'(1);
  assign pat_ra = j_r[IDX_W-1:0];
  assign pre_ra = (j_r == '0) ? '0 : jm1[IDX_W-1:0];
  assign pat_wa = plen_r[IDX_W-1:0];
  assign pre_wa = plen_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= byte_r;
    end
    pat_rd_r <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_wa] <= pre_wd;
    end
    pre_rd_r <= pre_mem[pre_ra];
  end

  always_comb begin
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    pos_at_nxt    = pos_at_r;
    plen_nxt      = plen_r;
    bpl_nxt       = bpl_r;
    mlen_nxt      = mlen_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    mstart_nxt    = mstart_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    out_ovf_nxt   = out_ovf_r;
    out_eot_nxt   = out_eot_r;
    pat_we        = 1'b0;
    pre_we        = 1'b0;
    pre_wd        = '0;
    walk          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (ucw.op)
      kmp_pkg::DP_ACCEPT: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          byte_nxt = in_data;
          last_nxt = in_last;
          if (!in_operation) begin
            if (in_restart) begin
              plen_nxt = '0;
              bpl_nxt  = '0;
              ovf_nxt  = 1'b0;
            end
            mlen_nxt   = '0;
            pos_nxt    = '0;
            found_nxt  = 1'b0;
            mstart_nxt = '0;
          end else begin
            if (in_restart) begin
              mlen_nxt   = '0;
              found_nxt  = 1'b0;
              mstart_nxt = '0;
            end
            pos_at_nxt = pos_base;
            pos_nxt    = (pos_base == '1) ? pos_base : pos_base + POS_W'(1);
          end
        end
      end
      kmp_pkg::DP_SETUP: begin
        if (!op_r) begin
          if (plen_r >= MAX_LEN) begin
            ovf_nxt = 1'b1;
          end else if (plen_r == '0) begin
            pat_we   = 1'b1;
            pre_we   = 1'b1;
            bpl_nxt  = '0;
            plen_nxt = LEN_W'(1);
          end else begin
            pat_we = 1'b1;
            j_nxt  = bpl_r;
            walk   = 1'b1;
          end
        end else begin
          if (found_r || ovf_r) begin
            found_nxt = found_r;
          end else if (plen_r == '0) begin
            found_nxt  = 1'b1;
            mstart_nxt = '0;
          end else begin
            j_nxt = mlen_r;
            walk  = 1'b1;
          end
        end
      end
      kmp_pkg::DP_READ: begin
        walk = 1'b0;
      end
      kmp_pkg::DP_CMP: begin
        if (pat_rd_r == byte_r) begin
          j_nxt = j_r + LEN_W'(1);
        end else if (j_r != '0) begin
          j_nxt = LEN_W'(pre_rd_r);
          walk  = 1'b1;
        end
      end
      kmp_pkg::DP_COMMIT: begin
        if (!op_r) begin
          pre_we   = 1'b1;
          pre_wd   = j_r[IDX_W-1:0];
          bpl_nxt  = j_r;
          plen_nxt = plen_r + LEN_W'(1);
        end else begin
          mlen_nxt = j_r;
          if (j_r == plen_r) begin
            found_nxt  = 1'b1;
            mstart_nxt = pos_at_r + POS_W'(1) - POS_W'(plen_r);
          end
        end
      end
      kmp_pkg::DP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_index_nxt = found_r ? mstart_r : '0;
          out_ovf_nxt   = ovf_r;
          out_eot_nxt   = last_r;
        end
      end
      default: begin
        walk = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    j_r         <= j_nxt;
    pos_at_r    <= pos_at_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_eot_r   <= out_eot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      bpl_r       <= '0;
      mlen_r      <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      mstart_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      bpl_r       <= bpl_nxt;
      mlen_r      <= mlen_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      mstart_r    <= mstart_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_match_index      = out_index_r;
  assign out_pattern_overflow = out_ovf_r;
  assign out_end_of_text      = out_eot_r;

endmodule

[sv/kmp_chk.sv]
`include "kmp_substring_search_core_macros.svh"

module kmp_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_found,
  input logic [kmp_pkg::POS_W-1:0]  out_match_index,
  input logic                       out_pattern_overflow,
  input logic                       out_end_of_text
);

  `KMP_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `KMP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_match_index) && $stable(out_pattern_overflow) && $stable(out_end_of_text), "stalled result beat changed")
  `KMP_ASSERT(a_index_zero, out_valid && !out_found |-> out_match_index == '0, "index set without match")
  `KMP_ASSERT(a_ovf_no_match, out_valid && out_pattern_overflow |-> !out_found, "match reported on overflowed pattern")
  `KMP_ASSERT(a_busy_after_beat, in_valid && !in_stall |=> in_stall, "input beat taken on back to back cycles")

endmodule

bind kmp_substring_search_core kmp_chk u_kmp_chk (.*);
